// ===== rtl/core/hhst_pkg.sv =====
package hhst_pkg;

    localparam int SLOT_BITS    = 11;
    localparam int PROBE_LIMIT  = 8;
    localparam int SIZE_BUCKETS = 12;
    localparam int SIZE_CLASSES = 64;
    localparam int TABLE_SIZE   = 1 << SLOT_BITS;
    localparam int PROBE_BITS   = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

    localparam logic [63:0] KEY_MIX = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] SPREAD  = 64'h9E3779B97F4A7C15;
    localparam logic [31:0] THRESHOLD_RESET = 32'd4096;

    typedef enum logic [2:0] {
        OUT_HIT   = 3'd0,
        OUT_NEW   = 3'd1,
        OUT_EVICT = 3'd2,
        OUT_DROP  = 3'd3,
        OUT_READ  = 3'd4
    } outcome_t;

    typedef enum logic [0:0] {
        CMD_RECORD = 1'b0,
        CMD_READ   = 1'b1
    } command_t;

    typedef struct packed {
        logic [47:0] addr;
        logic [7:0]  tag;
        logic [63:0] count;
        logic [63:0] bytes;
        logic [63:0] inherited;
        logic [63:0] inherited_bytes;
        logic [63:0] large_cnt;
        logic [63:0] class_map;
    } entry_t;

    typedef logic [SIZE_BUCKETS-1:0][31:0] hist_row_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_TAG,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_PINIT,
        ST_PRD,
        ST_PCHK,
        ST_FETCH,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       tag_mix;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       probe_init;
        logic       probe_chk;
        logic       sel_target;
        logic       update;
        logic       clear_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic is_read;
        logic is_drop;
        logic probe_done;
        logic clear_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/core/hhst_ram.sv =====
module hhst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/hhst_ctrl.sv =====
module hhst_ctrl import hhst_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.is_read) begin
                    state_next = ST_FETCH;
                end else if (status.is_drop) begin
                    state_next = ST_UPDATE;
                end else begin
                    state_next = ST_TAG;
                end
            end
            ST_TAG: begin
                cmd.tag_mix = 1'b1;
                state_next  = ST_MUL0;
            end
            ST_MUL0: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = 2'd0;
                state_next   = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = 2'd1;
                state_next   = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = 2'd2;
                state_next   = ST_PINIT;
            end
            ST_PINIT: begin
                cmd.probe_init = 1'b1;
                state_next     = ST_PRD;
            end
            ST_PRD: begin
                state_next = ST_PCHK;
            end
            ST_PCHK: begin
                cmd.probe_chk = 1'b1;
                state_next    = status.probe_done ? ST_FETCH : ST_PRD;
            end
            ST_FETCH: begin
                cmd.sel_target = 1'b1;
                state_next     = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.sel_target = 1'b1;
                if (status.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/hhst_dp.sv =====
module hhst_dp import hhst_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_wdata,
    input  logic                 s_command,
    input  logic [47:0]          s_site_address,
    input  logic [7:0]           s_purpose_tag,
    input  logic [47:0]          s_request_bytes,
    input  logic [5:0]           s_size_class,
    input  logic [3:0]           s_size_bucket,
    input  logic [SLOT_BITS-1:0] s_read_slot,
    input  logic [3:0]           s_read_bucket,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_outcome,
    output logic [SLOT_BITS-1:0] m_slot_index,
    output logic [47:0]          m_entry_address,
    output logic [7:0]           m_entry_tag,
    output logic [63:0]          m_entry_count,
    output logic [63:0]          m_entry_bytes,
    output logic [63:0]          m_entry_inherited,
    output logic [63:0]          m_entry_inherited_bytes,
    output logic [63:0]          m_entry_large,
    output logic [63:0]          m_entry_class_map,
    output logic [31:0]          m_bucket_count,
    output logic [63:0]          m_eviction_total
);

    logic [31:0]          threshold_reg;
    logic [47:0]          addr_reg;
    logic [7:0]           tag_reg;
    logic [47:0]          bytes_reg;
    logic [5:0]           cls_reg;
    logic [3:0]           bkt_reg;
    logic [3:0]           rbkt_reg;
    outcome_t             outcome_reg;
    logic [63:0]          x_reg;
    logic [63:0]          acc_reg;
    logic [SLOT_BITS-1:0] probe_slot_reg;
    logic [PROBE_BITS-1:0] probe_cnt_reg;
    logic [SLOT_BITS-1:0] weak_slot_reg;
    logic [63:0]          weak_cnt_reg;
    logic [SLOT_BITS-1:0] target_reg;
    logic [SLOT_BITS-1:0] clr_idx_reg;
    logic [63:0]          evict_reg;
    logic                 m_valid_reg;
    entry_t               out_entry_reg;
    outcome_t             out_outcome_reg;
    logic [SLOT_BITS-1:0] out_slot_reg;
    logic [31:0]          out_bucket_reg;

    entry_t               rd_entry, new_entry;
    hist_row_t            rd_hist, new_hist;
    logic                 ram_we;
    logic [SLOT_BITS-1:0] ram_waddr, ram_raddr;
    entry_t               ram_wentry;
    hist_row_t            ram_whist;
    logic                 hit, empty, less, is_large, bkt_ok, rbkt_ok;
    logic [SLOT_BITS-1:0] weak_slot_next;
    logic [63:0]          weak_cnt_next, cls_bit, mul_p;
    logic [31:0]          bucket_val;

    hhst_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_SIZE)) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    hhst_ram #(.WIDTH($bits(hist_row_t)), .DEPTH(TABLE_SIZE)) u_hist_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_whist),
        .raddr (ram_raddr),
        .rdata (rd_hist)
    );

    assign ram_raddr  = cmd.sel_target ? target_reg : probe_slot_reg;
    assign ram_we     = cmd.clear_wr
                        || (cmd.update && outcome_reg != OUT_READ && outcome_reg != OUT_DROP);
    assign ram_waddr  = cmd.clear_wr ? clr_idx_reg : target_reg;
    assign ram_wentry = cmd.clear_wr ? '0 : new_entry;
    assign ram_whist  = cmd.clear_wr ? '0 : new_hist;

    assign hit   = rd_entry.addr == addr_reg && rd_entry.tag == tag_reg;
    assign empty = rd_entry.addr == '0;
    assign less  = rd_entry.count < weak_cnt_reg;
    assign weak_slot_next = less ? probe_slot_reg : weak_slot_reg;
    assign weak_cnt_next  = less ? rd_entry.count : weak_cnt_reg;

    assign is_large = bytes_reg > {16'd0, threshold_reg};
    assign bkt_ok   = {1'b0, bkt_reg} < 5'(SIZE_BUCKETS);
    assign rbkt_ok  = {1'b0, rbkt_reg} < 5'(SIZE_BUCKETS);
    assign cls_bit  = ({1'b0, cls_reg} < 7'(SIZE_CLASSES)) ? (64'd1 << cls_reg) : 64'd0;

    always_comb begin
        case (cmd.mul_step)
            2'd0:    mul_p = 64'(x_reg[31:0] * SPREAD[31:0]);
            2'd1:    mul_p = 64'(x_reg[63:32] * SPREAD[31:0]);
            default: mul_p = 64'(x_reg[31:0] * SPREAD[63:32]);
        endcase
    end

    always_comb begin
        new_entry           = rd_entry;
        new_hist            = rd_hist;
        new_entry.addr      = addr_reg;
        new_entry.tag       = tag_reg;
        new_entry.count     = rd_entry.count + 64'd1;
        new_entry.bytes     = rd_entry.bytes + {16'd0, bytes_reg};
        new_entry.large_cnt = rd_entry.large_cnt + (is_large ? 64'd1 : 64'd0);
        if (outcome_reg == OUT_EVICT) begin
            new_entry.inherited       = rd_entry.count;
            new_entry.inherited_bytes = rd_entry.bytes;
            new_entry.class_map       = is_large ? 64'd0 : cls_bit;
            new_hist                  = '0;
            if (bkt_ok) begin
                new_hist[bkt_reg] = 32'd1;
            end
        end else begin
            new_entry.class_map = rd_entry.class_map | (is_large ? 64'd0 : cls_bit);
            if (bkt_ok) begin
                new_hist[bkt_reg] = rd_hist[bkt_reg] + 32'd1;
            end
        end
    end

    always_comb begin
        bucket_val = 32'd0;
        if (outcome_reg == OUT_READ) begin
            if (rbkt_ok) begin
                bucket_val = rd_hist[rbkt_reg];
            end
        end else if (bkt_ok) begin
            bucket_val = new_hist[bkt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            clr_idx_reg   <= '0;
            evict_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                threshold_reg <= cfg_wdata;
            end
            if (cmd.clear_wr) begin
                clr_idx_reg <= clr_idx_reg + SLOT_BITS'(1);
            end
            if (cmd.update && outcome_reg == OUT_EVICT) begin
                evict_reg <= evict_reg + 64'd1;
            end
            if (cmd.update) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg    <= s_site_address;
            tag_reg     <= s_purpose_tag;
            bytes_reg   <= s_request_bytes;
            cls_reg     <= s_size_class;
            bkt_reg     <= s_size_bucket;
            rbkt_reg    <= s_read_bucket;
            target_reg  <= s_read_slot;
            if (s_command == CMD_READ) begin
                outcome_reg <= OUT_READ;
            end else if (s_site_address == '0) begin
                outcome_reg <= OUT_DROP;
            end else begin
                outcome_reg <= OUT_HIT;
            end
        end
        if (cmd.tag_mix) begin
            x_reg <= {16'd0, addr_reg} ^ 64'(tag_reg * KEY_MIX);
        end
        if (cmd.mul_en) begin
            if (cmd.mul_step == 2'd0) begin
                acc_reg <= mul_p;
            end else begin
                acc_reg <= acc_reg + {mul_p[31:0], 32'd0};
            end
        end
        if (cmd.probe_init) begin
            probe_slot_reg <= acc_reg[63 -: SLOT_BITS];
            weak_slot_reg  <= acc_reg[63 -: SLOT_BITS];
            weak_cnt_reg   <= '1;
            probe_cnt_reg  <= '0;
        end
        if (cmd.probe_chk) begin
            if (hit || empty) begin
                target_reg  <= probe_slot_reg;
                outcome_reg <= hit ? OUT_HIT : OUT_NEW;
            end else begin
                weak_slot_reg  <= weak_slot_next;
                weak_cnt_reg   <= weak_cnt_next;
                probe_slot_reg <= probe_slot_reg + SLOT_BITS'(1);
                probe_cnt_reg  <= probe_cnt_reg + PROBE_BITS'(1);
                target_reg     <= weak_slot_next;
                outcome_reg    <= OUT_EVICT;
            end
        end
        if (cmd.update) begin
            out_outcome_reg <= outcome_reg;
            out_slot_reg    <= target_reg;
            out_bucket_reg  <= bucket_val;
            if (outcome_reg == OUT_READ) begin
                out_entry_reg <= rd_entry;
            end else if (outcome_reg == OUT_DROP) begin
                out_entry_reg  <= '0;
                out_slot_reg   <= '0;
                out_bucket_reg <= '0;
            end else begin
                out_entry_reg <= new_entry;
            end
        end
    end

    assign status.is_read    = outcome_reg == OUT_READ;
    assign status.is_drop    = outcome_reg == OUT_DROP;
    assign status.probe_done = hit || empty
                               || probe_cnt_reg == PROBE_BITS'(PROBE_LIMIT - 1);
    assign status.clear_done = clr_idx_reg == SLOT_BITS'(TABLE_SIZE - 1);
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid                 = m_valid_reg;
    assign m_outcome               = out_outcome_reg;
    assign m_slot_index            = out_slot_reg;
    assign m_entry_address         = out_entry_reg.addr;
    assign m_entry_tag             = out_entry_reg.tag;
    assign m_entry_count           = out_entry_reg.count;
    assign m_entry_bytes           = out_entry_reg.bytes;
    assign m_entry_inherited       = out_entry_reg.inherited;
    assign m_entry_inherited_bytes = out_entry_reg.inherited_bytes;
    assign m_entry_large           = out_entry_reg.large_cnt;
    assign m_entry_class_map       = out_entry_reg.class_map;
    assign m_bucket_count          = out_bucket_reg;
    assign m_eviction_total        = evict_reg;

endmodule

// ===== rtl/core/heavy_hitter_site_table.sv =====
// steps: read decode, fetch, update; drop decode, update; record adds tag mix, hash, probing
// one transaction at a time; each probe slot takes a registered read of the
//   entry ram, up to 8 probes after a 3-step 32x32 multiply hash
// reset: synchronous active low; a clearing pass zeroes all 2048 slots of the entry and
//   histogram rams, no transaction accepted during it; threshold resets to 4096
module heavy_hitter_site_table import hhst_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic [47:0]          s_site_address,
    input  logic [7:0]           s_purpose_tag,
    input  logic [47:0]          s_request_bytes,
    input  logic [5:0]           s_size_class,
    input  logic [3:0]           s_size_bucket,
    input  logic [SLOT_BITS-1:0] s_read_slot,
    input  logic [3:0]           s_read_bucket,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_outcome,
    output logic [SLOT_BITS-1:0] m_slot_index,
    output logic [47:0]          m_entry_address,
    output logic [7:0]           m_entry_tag,
    output logic [63:0]          m_entry_count,
    output logic [63:0]          m_entry_bytes,
    output logic [63:0]          m_entry_inherited,
    output logic [63:0]          m_entry_inherited_bytes,
    output logic [63:0]          m_entry_large,
    output logic [63:0]          m_entry_class_map,
    output logic [31:0]          m_bucket_count,
    output logic [63:0]          m_eviction_total
);

    dp_cmd_t    cmd;
    dp_status_t status;

    hhst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hhst_dp u_dp (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cmd                     (cmd),
        .status                  (status),
        .cfg_we                  (cfg_we),
        .cfg_wdata               (cfg_wdata),
        .s_command               (s_command),
        .s_site_address          (s_site_address),
        .s_purpose_tag           (s_purpose_tag),
        .s_request_bytes         (s_request_bytes),
        .s_size_class            (s_size_class),
        .s_size_bucket           (s_size_bucket),
        .s_read_slot             (s_read_slot),
        .s_read_bucket           (s_read_bucket),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_outcome               (m_outcome),
        .m_slot_index            (m_slot_index),
        .m_entry_address         (m_entry_address),
        .m_entry_tag             (m_entry_tag),
        .m_entry_count           (m_entry_count),
        .m_entry_bytes           (m_entry_bytes),
        .m_entry_inherited       (m_entry_inherited),
        .m_entry_inherited_bytes (m_entry_inherited_bytes),
        .m_entry_large           (m_entry_large),
        .m_entry_class_map       (m_entry_class_map),
        .m_bucket_count          (m_bucket_count),
        .m_eviction_total        (m_eviction_total)
    );

endmodule

// ===== rtl/core/hhst_checker.sv =====
module hhst_checker import hhst_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_outcome,
    input logic [63:0] m_entry_count,
    input logic [63:0] m_entry_inherited,
    input logic [47:0] m_entry_address
);

    // held result does not change while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_outcome) && $stable(m_entry_count))
        else $error("result changed while stalled");

    // an evicted slot counts one past what it inherited
    a_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outcome == OUT_EVICT |-> m_entry_count == m_entry_inherited + 64'd1)
        else $error("eviction count mismatch");

    // a slot taken from empty holds exactly one request
    a_new: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outcome == OUT_NEW |-> m_entry_count == 64'd1)
        else $error("new slot count not one");

    // dropped transactions report an empty entry
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outcome == OUT_DROP |-> m_entry_address == '0 && m_entry_count == '0)
        else $error("dropped transaction reports data");

endmodule

bind heavy_hitter_site_table hhst_checker u_hhst_checker (.*);

// ===== sim/heavy_hitter_site_table_tb.sv =====
`default_nettype none

module heavy_hitter_site_table_tb import hhst_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        command_t    command;
        logic [47:0] site_address;
        logic [7:0]  purpose_tag;
        logic [47:0] request_bytes;
        logic [5:0]  size_class;
        logic [3:0]  size_bucket;
        logic [10:0] read_slot;
        logic [3:0]  read_bucket;
    } request_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [10:0] slot_index;
        logic [47:0] entry_address;
        logic [7:0]  entry_tag;
        logic [63:0] entry_count;
        logic [63:0] entry_bytes;
        logic [63:0] entry_inherited;
        logic [63:0] entry_inherited_bytes;
        logic [63:0] entry_large;
        logic [63:0] entry_class_map;
        logic [31:0] bucket_count;
        logic [63:0] eviction_total;
    } reply_t;

    class site_table_scoreboard;
        bit [47:0] site_addr [TABLE_SIZE];
        bit [7:0]  site_tag  [TABLE_SIZE];
        bit [63:0] hits      [TABLE_SIZE];
        bit [63:0] byte_sum  [TABLE_SIZE];
        bit [63:0] class_map [TABLE_SIZE];
        bit [63:0] large_hits[TABLE_SIZE];
        bit [63:0] inh_count [TABLE_SIZE];
        bit [63:0] inh_bytes [TABLE_SIZE];
        bit [31:0] hist      [TABLE_SIZE][SIZE_BUCKETS];
        bit [63:0] evictions;
        bit [31:0] threshold = THRESHOLD_RESET;
        reply_t    awaited[$];
        int        errors;

        function int unsigned home_of(logic [47:0] a, logic [7:0] t);
            logic [63:0] x;
            logic [63:0] p;
            x = {16'd0, a} ^ (64'(t) * KEY_MIX);
            p = x * SPREAD;
            return p[63:64-SLOT_BITS];
        endfunction

        function reply_t snapshot(outcome_t oc, int unsigned s, logic [3:0] bkt);
            reply_t r;
            r.outcome               = oc;
            r.slot_index            = 11'(s);
            r.entry_address         = site_addr[s];
            r.entry_tag             = site_tag[s];
            r.entry_count           = hits[s];
            r.entry_bytes           = byte_sum[s];
            r.entry_inherited       = inh_count[s];
            r.entry_inherited_bytes = inh_bytes[s];
            r.entry_large           = large_hits[s];
            r.entry_class_map       = class_map[s];
            r.bucket_count          = (bkt < SIZE_BUCKETS) ? hist[s][bkt] : 32'd0;
            r.eviction_total        = evictions;
            return r;
        endfunction

        function void note_request(request_t q);
            int unsigned s;
            int unsigned weakest;
            bit is_large;
            bit [63:0] cbit;
            reply_t r;
            if (q.command == CMD_READ) begin
                awaited.push_back(snapshot(OUT_READ, q.read_slot, q.read_bucket));
                return;
            end
            if (q.site_address == 0) begin
                r = '0;
                r.outcome = OUT_DROP;
                r.eviction_total = evictions;
                awaited.push_back(r);
                return;
            end
            is_large = q.request_bytes > threshold;
            cbit = (q.size_class < SIZE_CLASSES) ? (64'd1 << q.size_class) : 64'd0;
            s = home_of(q.site_address, q.purpose_tag);
            weakest = s;
            for (int p = 0; p < PROBE_LIMIT; p++) begin
                if ((site_addr[s] == q.site_address && site_tag[s] == q.purpose_tag)
                        || site_addr[s] == 0) begin
                    outcome_t oc;
                    oc = (site_addr[s] == 0) ? OUT_NEW : OUT_HIT;
                    site_addr[s] = q.site_address;
                    site_tag[s]  = q.purpose_tag;
                    hits[s]     += 1;
                    byte_sum[s] += q.request_bytes;
                    if (is_large) large_hits[s] += 1;
                    else class_map[s] |= cbit;
                    if (q.size_bucket < SIZE_BUCKETS) hist[s][q.size_bucket] += 1;
                    awaited.push_back(snapshot(oc, s, q.size_bucket));
                    return;
                end
                if (hits[s] < hits[weakest]) weakest = s;
                s = (s + 1) % TABLE_SIZE;
            end
            s = weakest;
            site_addr[s] = q.site_address;
            site_tag[s]  = q.purpose_tag;
            inh_count[s] = hits[s];
            inh_bytes[s] = byte_sum[s];
            hits[s]     += 1;
            byte_sum[s] += q.request_bytes;
            class_map[s] = 0;
            if (is_large) large_hits[s] += 1;
            else class_map[s] = cbit;
            for (int b = 0; b < SIZE_BUCKETS; b++) hist[s][b] = 0;
            if (q.size_bucket < SIZE_BUCKETS) hist[s][q.size_bucket] = 1;
            evictions += 1;
            awaited.push_back(snapshot(OUT_EVICT, s, q.size_bucket));
        endfunction

        function void field(string n, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch %s: expected %h, got %h", n, e, a);
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t e;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected transaction on result side");
                return;
            end
            e = awaited.pop_front();
            field("outcome", 64'(e.outcome), 64'(got.outcome));
            field("slot_index", 64'(e.slot_index), 64'(got.slot_index));
            field("entry_address", 64'(e.entry_address), 64'(got.entry_address));
            field("entry_tag", 64'(e.entry_tag), 64'(got.entry_tag));
            field("entry_count", e.entry_count, got.entry_count);
            field("entry_bytes", e.entry_bytes, got.entry_bytes);
            field("entry_inherited", e.entry_inherited, got.entry_inherited);
            field("entry_inherited_bytes", e.entry_inherited_bytes,
                  got.entry_inherited_bytes);
            field("entry_large", e.entry_large, got.entry_large);
            field("entry_class_map", e.entry_class_map, got.entry_class_map);
            field("bucket_count", 64'(e.bucket_count), 64'(got.bucket_count));
            field("eviction_total", e.eviction_total, got.eviction_total);
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_command = 0;
    logic [47:0] s_site_address = '0;
    logic [7:0]  s_purpose_tag = '0;
    logic [47:0] s_request_bytes = '0;
    logic [5:0]  s_size_class = '0;
    logic [3:0]  s_size_bucket = '0;
    logic [10:0] s_read_slot = '0;
    logic [3:0]  s_read_bucket = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [2:0]  m_outcome;
    logic [10:0] m_slot_index;
    logic [47:0] m_entry_address;
    logic [7:0]  m_entry_tag;
    logic [63:0] m_entry_count;
    logic [63:0] m_entry_bytes;
    logic [63:0] m_entry_inherited;
    logic [63:0] m_entry_inherited_bytes;
    logic [63:0] m_entry_large;
    logic [63:0] m_entry_class_map;
    logic [31:0] m_bucket_count;
    logic [63:0] m_eviction_total;

    bit steady;
    bit hold_req;
    site_table_scoreboard sb = new();
    logic [47:0] pool_addr[20];
    logic [7:0]  pool_tag[20];

    heavy_hitter_site_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_site_address(s_site_address),
        .s_purpose_tag(s_purpose_tag), .s_request_bytes(s_request_bytes),
        .s_size_class(s_size_class), .s_size_bucket(s_size_bucket),
        .s_read_slot(s_read_slot), .s_read_bucket(s_read_bucket),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_outcome(m_outcome), .m_slot_index(m_slot_index),
        .m_entry_address(m_entry_address), .m_entry_tag(m_entry_tag),
        .m_entry_count(m_entry_count), .m_entry_bytes(m_entry_bytes),
        .m_entry_inherited(m_entry_inherited),
        .m_entry_inherited_bytes(m_entry_inherited_bytes),
        .m_entry_large(m_entry_large), .m_entry_class_map(m_entry_class_map),
        .m_bucket_count(m_bucket_count), .m_eviction_total(m_eviction_total)
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    task automatic offer(request_t q);
        s_valid         <= 1;
        s_command       <= q.command;
        s_site_address  <= q.site_address;
        s_purpose_tag   <= q.purpose_tag;
        s_request_bytes <= q.request_bytes;
        s_size_class    <= q.size_class;
        s_size_bucket   <= q.size_bucket;
        s_read_slot     <= q.read_slot;
        s_read_bucket   <= q.read_bucket;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(q);
        if (!steady && $urandom_range(0, 99) < 18) begin
            s_valid <= 0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 40);
        end
    endtask

    task automatic drain_and_write(logic [31:0] v);
        s_valid <= 0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        sb.threshold = v;
    endtask

    function automatic request_t record_of(logic [47:0] a, logic [7:0] t);
        request_t q;
        q.command       = CMD_RECORD;
        q.site_address  = a;
        q.purpose_tag   = t;
        case ($urandom_range(0, 3))
            0: q.request_bytes = 48'({$urandom, $urandom});
            1: q.request_bytes = 48'(sb.threshold) + 48'($urandom_range(0, 2)) - 48'd1;
            default: q.request_bytes = 48'($urandom_range(0, 8192));
        endcase
        q.size_class  = 6'($urandom);
        q.size_bucket = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                                    : 4'($urandom_range(0, 11));
        q.read_slot   = 11'($urandom);
        q.read_bucket = 4'($urandom);
        return q;
    endfunction

    function automatic request_t random_request();
        request_t q;
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 60) begin
            k = $urandom_range(0, 19);
            q = record_of(pool_addr[k], pool_tag[k]);
        end else if (k < 75) begin
            q = record_of(48'({$urandom, $urandom}), 8'($urandom));
        end else if (k < 82) begin
            q = record_of(48'd0, 8'($urandom));
        end else begin
            q = record_of(48'({$urandom, $urandom}), 8'($urandom));
            q.command     = CMD_READ;
            q.read_bucket = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 1)) q.read_slot = 11'(2044 + $urandom_range(0, 15));
        end
        return q;
    endfunction

    always begin
        if (hold_req) begin
            m_ready <= 0;
            repeat (400) @(posedge aclk);
            hold_req = 0;
        end else begin
            m_ready <= steady || $urandom_range(0, 99) >= 18;
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_reply({m_outcome, m_slot_index, m_entry_address, m_entry_tag,
                                m_entry_count, m_entry_bytes, m_entry_inherited,
                                m_entry_inherited_bytes, m_entry_large,
                                m_entry_class_map, m_bucket_count, m_eviction_total});
        end
    end

    initial begin
        #4ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        request_t q;
        int unsigned h;
        logic [31:0] settings[4];

        // keys whose home slot lies around the wrap point of the table
        for (int i = 0; i < 20; i++) begin
            do begin
                pool_addr[i] = 48'({$urandom, $urandom});
                pool_tag[i]  = 8'($urandom);
                h = sb.home_of(pool_addr[i], pool_tag[i]);
            end while (pool_addr[i] == 0 || (h < 2044 && h > 3));
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1;

        q = record_of(48'hFFFF_FFFF_FFFF, 8'hFF);
        q.request_bytes = 48'hFFFF_FFFF_FFFF; q.size_class = 6'd63; q.size_bucket = 4'd11;
        offer(q);
        q.request_bytes = 48'd4096; q.size_class = 6'd0; q.size_bucket = 4'd0;
        offer(q);
        q.request_bytes = 48'd4097; q.size_bucket = 4'd12;
        offer(q);
        q.request_bytes = 48'd0; q.size_bucket = 4'd15; q.size_class = 6'd42;
        offer(q);
        q = record_of(48'd0, 8'hA5);
        offer(q);
        q.command = CMD_READ;
        q.read_slot = 11'(sb.home_of(48'hFFFF_FFFF_FFFF, 8'hFF));
        q.read_bucket = 4'd11;
        offer(q);
        q.read_bucket = 4'd15;
        offer(q);
        q.read_slot = 11'd0; q.read_bucket = 4'd0;
        offer(q);
        q.read_slot = 11'h7FF; q.read_bucket = 4'd12;
        offer(q);
        // ten keys homed near the wrap point, which may collide and force an eviction
        for (int i = 0; i < 10; i++) offer(record_of(pool_addr[i], pool_tag[i]));
        q.read_slot = 11'd2047; q.read_bucket = 4'd5;
        offer(q);

        settings[0] = THRESHOLD_RESET;
        settings[1] = 32'd0;
        settings[2] = 32'hFFFF_FFFF;
        settings[3] = $urandom_range(1, 20000);
        for (int ph = 0; ph < 4; ph++) begin
            drain_and_write(settings[ph]);
            for (int i = 0; i < 320; i++) begin
                steady = (ph == 0 && i >= 100 && i < 250);
                if (ph == 1 && i == 150) hold_req = 1;
                offer(random_request());
            end
            steady = 0;
        end
        s_valid <= 0;

        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/hhst_pkg.sv
rtl/core/hhst_ram.sv
rtl/core/hhst_ctrl.sv
rtl/core/hhst_dp.sv
rtl/core/heavy_hitter_site_table.sv
rtl/core/hhst_checker.sv
sim/heavy_hitter_site_table_tb.sv
